// ===== hw/rtl/gcd_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the
// great-circle distance pipeline. No dependencies.
package gcd_pkg;

  localparam int ITER   = 60;
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int U_W    = 31;
  localparam int UNIT_W = 61;
  localparam int MUL_W  = 62;
  localparam int PROD_W = 124;
  localparam int A_W    = 121;
  localparam int DIST_W = 31;

  typedef logic signed [63:0] ang_t;

  localparam logic signed [LAT_W-1:0] LAT_POS = 31'sd900000000;
  localparam logic signed [LAT_W-1:0] LAT_NEG = -31'sd900000000;
  localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
  localparam logic [DIST_W-1:0] DIST_MAX   = 31'd2001600000;
  localparam logic [DIST_W-1:0] RADIUS_CM2 = 31'd1274200000;
  localparam logic [A_W-1:0] ONE120 = {1'b1, 120'b0};
  localparam logic [UNIT_W-1:0] ONE60 = {1'b1, 60'b0};

  // shift-subtract division, elaboration only
  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [63:0] d);
    logic [64:0]  rem;
    logic [127:0] q;
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // truncated Q62 arctangent series, stops at the first zero term
  function automatic logic [63:0] atan_series(input logic [63:0] t, input logic [63:0] dsq,
                                              input int sh);
    logic [63:0]  sum;
    logic [63:0]  tt;
    logic [127:0] q;
    logic         done;
    sum  = t;
    tt   = t;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        if (dsq != 0) begin
          q  = udiv({64'b0, tt}, dsq);
          tt = q[63:0];
        end else if (sh < 64) begin
          tt = tt >> sh;
        end else begin
          tt = '0;
        end
        if (tt == 0) begin
          done = 1'b1;
        end else begin
          q = udiv({64'b0, tt}, 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - q[63:0];
          else sum = sum + q[63:0];
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] calc_pi62();
    logic [63:0]  one62;
    logic [127:0] q5;
    logic [127:0] q239;
    one62 = 64'h4000_0000_0000_0000;
    q5    = udiv({64'b0, one62}, 64'd5);
    q239  = udiv({64'b0, one62}, 64'd239);
    return (atan_series(q5[63:0], 64'd25, 0) << 4)
         - (atan_series(q239[63:0], 64'd57121, 0) << 2);
  endfunction

  localparam logic [63:0] PI62 = calc_pi62();
  localparam ang_t HALF_PI = ang_t'(PI62 >> 3);

  function automatic ang_t atan_entry(input int i);
    if (i == 0) return ang_t'(PI62 >> 4);
    return ang_t'(atan_series(64'd1 << (62 - i), 64'd0, 2 * i) >> 2);
  endfunction

  // 1/G in Q60 from the Q62 gain product
  function automatic ang_t calc_k();
    logic [63:0]  g;
    logic [127:0] q;
    logic [127:0] n;
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    g = 64'h4000_0000_0000_0000;
    for (int i = 0; i < ITER; i++) begin
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    q = udiv({64'h4000_0000_0000_0000, 64'b0}, g);
    n = {64'b0, q[63:0]} << 56;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      cc = {64'b0, c} * {64'b0, c};
      if (cc <= n) r = c;
    end
    return ang_t'(r);
  endfunction

  function automatic logic [MUL_W-1:0] calc_conv();
    logic [127:0] q;
    q = udiv({64'b0, PI62} << 30, 64'd3600000000);
    return q[MUL_W-1:0];
  endfunction

  localparam ang_t K_START = calc_k();
  localparam logic [MUL_W-1:0] CONV_F = calc_conv();

endpackage

// ===== hw/rtl/gcd_in_if.sv =====
// Input channel: two positions per transfer.
// Uses gcd_pkg for field widths.
interface gcd_in_if;
  logic valid;
  logic ready;
  logic signed [gcd_pkg::LAT_W-1:0] lat_a;
  logic signed [gcd_pkg::LON_W-1:0] lon_a;
  logic signed [gcd_pkg::LAT_W-1:0] lat_b;
  logic signed [gcd_pkg::LON_W-1:0] lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

// ===== hw/rtl/gcd_out_if.sv =====
// Output channel: one distance per transfer.
// Uses gcd_pkg for the field width.
interface gcd_out_if;
  logic valid;
  logic ready;
  logic [gcd_pkg::DIST_W-1:0] distance_cm;
  modport source (output valid, distance_cm, input ready);
  modport sink (input valid, distance_cm, output ready);
endinterface

// ===== hw/rtl/gcd_mul.sv =====
// Two-stage 62x62 unsigned multiplier from four 31x31 partial products.
// Depends on gcd_pkg.
module gcd_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  logic [gcd_pkg::MUL_W-1:0] a,
  input  logic [gcd_pkg::MUL_W-1:0] b,
  output logic                      vld_out,
  output logic [gcd_pkg::PROD_W-1:0] prod
);
  logic        vld1;
  logic [61:0] pll, plh, phl, phh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld_out <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll  <= a[30:0] * b[30:0];
      plh  <= a[30:0] * b[61:31];
      phl  <= a[61:31] * b[30:0];
      phh  <= a[61:31] * b[61:31];
      prod <= ({62'b0, phh} << 62) + (({62'b0, plh} + {62'b0, phl}) << 31) + {62'b0, pll};
    end
  end
endmodule

// ===== hw/rtl/gcd_cordic_rot.sv =====
// Rotation-mode CORDIC, one iteration per stage, sine and cosine clamped
// to [0, 1] in Q60. Depends on gcd_pkg.
module gcd_cordic_rot (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  gcd_pkg::ang_t              z_in,
  output logic                       vld_out,
  output logic [gcd_pkg::UNIT_W-1:0] sin_q,
  output logic [gcd_pkg::UNIT_W-1:0] cos_q
);
  gcd_pkg::ang_t x [0:gcd_pkg::ITER];
  gcd_pkg::ang_t y [0:gcd_pkg::ITER];
  gcd_pkg::ang_t z [0:gcd_pkg::ITER];
  logic          vld [0:gcd_pkg::ITER];

  assign x[0]   = gcd_pkg::K_START;
  assign y[0]   = '0;
  assign z[0]   = z_in;
  assign vld[0] = vld_in;

  for (genvar i = 0; i < gcd_pkg::ITER; i++) begin : g_stage
    localparam gcd_pkg::ang_t ANG = gcd_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][63]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ANG;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ANG;
        end
      end
    end
  end

  logic [gcd_pkg::UNIT_W-1:0] sin_c, cos_c;

  always_comb begin
    if (y[gcd_pkg::ITER][63]) sin_c = '0;
    else if (y[gcd_pkg::ITER] > gcd_pkg::ang_t'(gcd_pkg::ONE60)) sin_c = gcd_pkg::ONE60;
    else sin_c = y[gcd_pkg::ITER][gcd_pkg::UNIT_W-1:0];
    if (x[gcd_pkg::ITER][63]) cos_c = '0;
    else if (x[gcd_pkg::ITER] > gcd_pkg::ang_t'(gcd_pkg::ONE60)) cos_c = gcd_pkg::ONE60;
    else cos_c = x[gcd_pkg::ITER][gcd_pkg::UNIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[gcd_pkg::ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sin_c;
      cos_q <= cos_c;
    end
  end
endmodule

// ===== hw/rtl/gcd_isqrt.sv =====
// Pipelined floor square root of a 121-bit value, one root bit per stage.
// Depends on gcd_pkg.
module gcd_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [gcd_pkg::A_W-1:0]    rad,
  output logic                       vld_out,
  output logic [gcd_pkg::UNIT_W-1:0] root
);
  localparam int RW = gcd_pkg::A_W + 2;

  logic [RW-1:0]              rem [0:gcd_pkg::UNIT_W];
  logic [gcd_pkg::UNIT_W-1:0] r   [0:gcd_pkg::UNIT_W];
  logic                       vld [0:gcd_pkg::UNIT_W];

  assign rem[0] = {2'b0, rad};
  assign r[0]   = '0;
  assign vld[0] = vld_in;

  for (genvar j = 0; j < gcd_pkg::UNIT_W; j++) begin : g_bit
    localparam int B = gcd_pkg::UNIT_W - 1 - j;
    logic [RW-1:0] trial;
    // (r + 2^B)^2 - r^2
    assign trial = ({(RW - gcd_pkg::UNIT_W)'(0), r[j]} << (B + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j] >= trial) begin
          rem[j+1] <= rem[j] - trial;
          r[j+1]   <= r[j] | ({{(gcd_pkg::UNIT_W-1){1'b0}}, 1'b1} << B);
        end else begin
          rem[j+1] <= rem[j];
          r[j+1]   <= r[j];
        end
      end
    end
  end

  assign vld_out = vld[gcd_pkg::UNIT_W];
  assign root    = r[gcd_pkg::UNIT_W];
endmodule

// ===== hw/rtl/gcd_cordic_vec.sv =====
// Vectoring-mode CORDIC giving atan2(y, x) in Q60, clamped to [0, pi/2].
// Depends on gcd_pkg.
module gcd_cordic_vec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [gcd_pkg::UNIT_W-1:0] y_in,
  input  logic [gcd_pkg::UNIT_W-1:0] x_in,
  output logic                       vld_out,
  output logic [gcd_pkg::MUL_W-1:0]  z_out
);
  gcd_pkg::ang_t x [0:gcd_pkg::ITER];
  gcd_pkg::ang_t y [0:gcd_pkg::ITER];
  gcd_pkg::ang_t z [0:gcd_pkg::ITER];
  logic          vld [0:gcd_pkg::ITER];

  assign x[0]   = gcd_pkg::ang_t'(x_in);
  assign y[0]   = gcd_pkg::ang_t'(y_in);
  assign z[0]   = '0;
  assign vld[0] = vld_in;

  for (genvar i = 0; i < gcd_pkg::ITER; i++) begin : g_stage
    localparam gcd_pkg::ang_t ANG = gcd_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y[i][63]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ANG;
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ANG;
        end
      end
    end
  end

  gcd_pkg::ang_t z_c;

  always_comb begin
    if (z[gcd_pkg::ITER][63]) z_c = '0;
    else if (z[gcd_pkg::ITER] > gcd_pkg::HALF_PI) z_c = gcd_pkg::HALF_PI;
    else z_c = z[gcd_pkg::ITER];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[gcd_pkg::ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) z_out <= z_c[gcd_pkg::MUL_W-1:0];
  end
endmodule

// ===== hw/rtl/great_circle_distance.sv =====
// Haversine great-circle distance, fixed point, fully pipelined.
// One item per cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is free,
// so a stalled output holds every stage in place.
// Synchronous reset clears all valid bits; the constant tables need no reset.
// Depends on gcd_pkg, gcd_in_if, gcd_out_if, gcd_mul, gcd_cordic_rot, gcd_isqrt, gcd_cordic_vec.
module great_circle_distance (
  input  logic       clk,
  input  logic       rst,
  gcd_in_if.sink     in_ch,
  gcd_out_if.source  out_ch
);
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: saturate latitudes, raw longitude difference
  logic                              v1;
  logic signed [gcd_pkg::LAT_W-1:0]  la_q, lb_q;
  logic signed [32:0]                dlon_q;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_ch.lat_a > gcd_pkg::LAT_POS) la_q <= gcd_pkg::LAT_POS;
      else if (in_ch.lat_a < gcd_pkg::LAT_NEG) la_q <= gcd_pkg::LAT_NEG;
      else la_q <= in_ch.lat_a;
      if (in_ch.lat_b > gcd_pkg::LAT_POS) lb_q <= gcd_pkg::LAT_POS;
      else if (in_ch.lat_b < gcd_pkg::LAT_NEG) lb_q <= gcd_pkg::LAT_NEG;
      else lb_q <= in_ch.lat_b;
      dlon_q <= 33'(in_ch.lon_b) - 33'(in_ch.lon_a);
    end
  end

  // stage 2: magnitudes in 1e-7 degree
  logic                    v2;
  logic [gcd_pkg::U_W-1:0] u_dlat, u_dlon, u_la, u_lb;
  logic signed [31:0]      dl;
  logic signed [33:0]      dw;
  logic signed [gcd_pkg::LAT_W-1:0] la_abs, lb_abs;

  always_comb begin
    dl = 32'(lb_q) - 32'(la_q);
    if (34'(dlon_q) > gcd_pkg::HALF_TURN) dw = 34'(dlon_q) - gcd_pkg::FULL_TURN;
    else if (34'(dlon_q) < -gcd_pkg::HALF_TURN) dw = 34'(dlon_q) + gcd_pkg::FULL_TURN;
    else dw = 34'(dlon_q);
    la_abs = la_q[gcd_pkg::LAT_W-1] ? -la_q : la_q;
    lb_abs = lb_q[gcd_pkg::LAT_W-1] ? -lb_q : lb_q;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_dlat <= dl[31] ? 31'(-dl) : dl[30:0];
      u_dlon <= dw[33] ? 31'(-dw) : dw[30:0];
      u_la   <= {la_abs[29:0], 1'b0};
      u_lb   <= {lb_abs[29:0], 1'b0};
    end
  end

  // half-angle conversion
  logic                         vh;
  logic [gcd_pkg::PROD_W-1:0]   ph_dlat, ph_dlon, ph_la, ph_lb;

  gcd_mul u_mh0 (.clk, .rst, .en, .vld_in(v2), .a(62'(u_dlat)), .b(gcd_pkg::CONV_F),
                 .vld_out(vh), .prod(ph_dlat));
  gcd_mul u_mh1 (.clk, .rst, .en, .vld_in(v2), .a(62'(u_dlon)), .b(gcd_pkg::CONV_F),
                 .vld_out(), .prod(ph_dlon));
  gcd_mul u_mh2 (.clk, .rst, .en, .vld_in(v2), .a(62'(u_la)), .b(gcd_pkg::CONV_F),
                 .vld_out(), .prod(ph_la));
  gcd_mul u_mh3 (.clk, .rst, .en, .vld_in(v2), .a(62'(u_lb)), .b(gcd_pkg::CONV_F),
                 .vld_out(), .prod(ph_lb));

  localparam logic [gcd_pkg::PROD_W-1:0] RND31 = {{(gcd_pkg::PROD_W-1){1'b0}}, 1'b1} << 31;

  logic                          vz;
  gcd_pkg::ang_t                 z_dlat, z_dlon, z_la, z_lb;
  logic [gcd_pkg::PROD_W-1:0]    sh0, sh1, sh2, sh3;

  assign sh0 = ph_dlat + RND31;
  assign sh1 = ph_dlon + RND31;
  assign sh2 = ph_la + RND31;
  assign sh3 = ph_lb + RND31;

  always_ff @(posedge clk) begin
    if (rst) vz <= 1'b0;
    else if (en) vz <= vh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_dlat <= sh0[95:32];
      z_dlon <= sh1[95:32];
      z_la   <= sh2[95:32];
      z_lb   <= sh3[95:32];
    end
  end

  // sines and cosines
  logic                       vr;
  logic [gcd_pkg::UNIT_W-1:0] p_rot, r_rot, ca, cb;

  gcd_cordic_rot u_rot0 (.clk, .rst, .en, .vld_in(vz), .z_in(z_dlat), .vld_out(vr),
                         .sin_q(p_rot), .cos_q());
  gcd_cordic_rot u_rot1 (.clk, .rst, .en, .vld_in(vz), .z_in(z_dlon), .vld_out(),
                         .sin_q(r_rot), .cos_q());
  gcd_cordic_rot u_rot2 (.clk, .rst, .en, .vld_in(vz), .z_in(z_la), .vld_out(),
                         .sin_q(), .cos_q(ca));
  gcd_cordic_rot u_rot3 (.clk, .rst, .en, .vld_in(vz), .z_in(z_lb), .vld_out(),
                         .sin_q(), .cos_q(cb));

  // p and r wait for the cosine products
  logic [gcd_pkg::UNIT_W-1:0] p_d [1:4];
  logic [gcd_pkg::UNIT_W-1:0] r_d [1:4];

  always_ff @(posedge clk) begin
    if (en) begin
      p_d[1] <= p_rot;
      r_d[1] <= r_rot;
      for (int k = 2; k <= 4; k++) begin
        p_d[k] <= p_d[k-1];
        r_d[k] <= r_d[k-1];
      end
    end
  end

  logic                       vm, vt, va;
  logic [gcd_pkg::PROD_W-1:0] pm, pt, pa0, pa1;

  gcd_mul u_mm (.clk, .rst, .en, .vld_in(vr), .a(62'(ca)), .b(62'(cb)),
                .vld_out(vm), .prod(pm));
  gcd_mul u_mt (.clk, .rst, .en, .vld_in(vm), .a(62'(pm[120:60])), .b(62'(r_d[2])),
                .vld_out(vt), .prod(pt));
  gcd_mul u_ma1 (.clk, .rst, .en, .vld_in(vt), .a(62'(pt[120:60])), .b(62'(r_d[4])),
                 .vld_out(va), .prod(pa1));
  gcd_mul u_ma0 (.clk, .rst, .en, .vld_in(vt), .a(62'(p_d[4])), .b(62'(p_d[4])),
                 .vld_out(), .prod(pa0));

  // haversine term, clamped to one
  logic                    vs1, vs2;
  logic [gcd_pkg::A_W:0]   a_sum;
  logic [gcd_pkg::A_W-1:0] a_q, na_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs1 <= 1'b0;
      vs2 <= 1'b0;
    end else if (en) begin
      vs1 <= va;
      vs2 <= vs1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum <= {1'b0, pa0[gcd_pkg::A_W-1:0]} + {1'b0, pa1[gcd_pkg::A_W-1:0]};
      if (a_sum > {1'b0, gcd_pkg::ONE120}) begin
        a_q  <= gcd_pkg::ONE120;
        na_q <= '0;
      end else begin
        a_q  <= a_sum[gcd_pkg::A_W-1:0];
        na_q <= gcd_pkg::ONE120 - a_sum[gcd_pkg::A_W-1:0];
      end
    end
  end

  logic                       vq;
  logic [gcd_pkg::UNIT_W-1:0] s_rt, c_rt;

  gcd_isqrt u_sq0 (.clk, .rst, .en, .vld_in(vs2), .rad(a_q), .vld_out(vq), .root(s_rt));
  gcd_isqrt u_sq1 (.clk, .rst, .en, .vld_in(vs2), .rad(na_q), .vld_out(), .root(c_rt));

  logic                      vv, vd;
  logic [gcd_pkg::MUL_W-1:0] z_ang;
  logic [gcd_pkg::PROD_W-1:0] pd, pd_rnd;

  gcd_cordic_vec u_vec (.clk, .rst, .en, .vld_in(vq), .y_in(s_rt), .x_in(c_rt),
                        .vld_out(vv), .z_out(z_ang));
  gcd_mul u_md (.clk, .rst, .en, .vld_in(vv), .a(z_ang), .b(62'(gcd_pkg::RADIUS_CM2)),
                .vld_out(vd), .prod(pd));

  assign pd_rnd = pd + ({{(gcd_pkg::PROD_W-1){1'b0}}, 1'b1} << 59);

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pd_rnd[123:60] > 64'(gcd_pkg::DIST_MAX)) out_ch.distance_cm <= gcd_pkg::DIST_MAX;
      else out_ch.distance_cm <= pd_rnd[90:60];
    end
  end

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.distance_cm <= gcd_pkg::DIST_MAX)
    else $error("distance above range");

  a_hav_clamp: assert property (@(posedge clk) disable iff (rst)
    vs2 |-> (a_q <= gcd_pkg::ONE120) && (a_q + na_q == gcd_pkg::ONE120))
    else $error("haversine term not clamped");

  a_free_accept: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipeline stalled with empty output");
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for great_circle_distance: directed table, then random positions.
// Depends on gcd_pkg, gcd_in_if, gcd_out_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 750;
  localparam int CYCLE_CAP = 250000;
  localparam int DRAIN     = 260;

  typedef struct {
    logic signed [gcd_pkg::LAT_W-1:0] lat_a;
    logic signed [gcd_pkg::LON_W-1:0] lon_a;
    logic signed [gcd_pkg::LAT_W-1:0] lat_b;
    logic signed [gcd_pkg::LON_W-1:0] lon_b;
    bit                               known;
    logic [gcd_pkg::DIST_W-1:0]       dist_val;
  } probe_t;

  logic clk;
  logic rst;
  gcd_in_if  in_ch();
  gcd_out_if out_ch();

  great_circle_distance dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // own trig tables, Q62 series for pi and the arctangents
  logic signed [63:0] arc_tab [gcd_pkg::ITER];
  logic signed [63:0] cordic_k;
  logic signed [63:0] quarter_turn;
  logic [63:0]        deg_to_rad;

  logic [gcd_pkg::DIST_W-1:0] dist_queue [$];
  int  err_count;
  int  sent_count;
  int  cycle_count;
  bit  stimulus_done;
  bit  hold_off;
  bit  calm;
  int  rx_wait;

  function automatic logic [63:0] arctan_q62(input logic [63:0] t, input logic [63:0] dsq,
                                             input int sh);
    logic [63:0] sum;
    sum = t;
    for (int k = 1; k < 64; k++) begin
      if (dsq != 0) t = t / dsq;
      else if (sh < 64) t = t >> sh;
      else t = 0;
      if (t == 0) break;
      if (k % 2 == 1) sum = sum - t / (2 * k + 1);
      else sum = sum + t / (2 * k + 1);
    end
    return sum;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'b0, c} * {64'b0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic void build_trig_tables();
    logic [63:0]  one62;
    logic [63:0]  pi62;
    logic [63:0]  g;
    logic [127:0] q;
    one62 = 64'd1 << 62;
    pi62  = 16 * arctan_q62(one62 / 5, 25, 0) - 4 * arctan_q62(one62 / 239, 57121, 0);
    arc_tab[0] = pi62 >> 4;
    for (int i = 1; i < gcd_pkg::ITER; i++)
      arc_tab[i] = arctan_q62(64'd1 << (62 - i), 0, 2 * i) >> 2;
    g = one62;
    for (int i = 0; i < gcd_pkg::ITER; i++) if (2 * i < 64) g = g + (g >> (2 * i));
    q = {one62, 64'b0} / {64'b0, g};
    cordic_k = root_floor({64'b0, q[63:0]} << 56);
    q = ({64'b0, pi62} << 30) / 128'd3600000000;
    deg_to_rad   = q[63:0];
    quarter_turn = pi62 >> 3;
  endfunction

  function automatic logic signed [63:0] half_rad(input logic [63:0] u);
    logic [127:0] p;
    p = {64'b0, u} * {64'b0, deg_to_rad} + (128'd1 << 31);
    return p[95:32];
  endfunction

  function automatic logic [63:0] unit_clamp(input logic signed [63:0] v);
    if (v < 0) return 0;
    if (v > (64'sd1 <<< 60)) return 64'd1 << 60;
    return v;
  endfunction

  function automatic void sin_cos(input logic signed [63:0] ang, output logic [63:0] s,
                                  output logic [63:0] c);
    logic signed [63:0] x, y, dx, dy;
    x = cordic_k;
    y = 0;
    for (int i = 0; i < gcd_pkg::ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x = x - dx; y = y + dy; ang = ang - arc_tab[i];
      end else begin
        x = x + dx; y = y - dy; ang = ang + arc_tab[i];
      end
    end
    s = unit_clamp(y);
    c = unit_clamp(x);
  endfunction

  function automatic logic signed [63:0] central_angle(input logic signed [63:0] y,
                                                        input logic signed [63:0] x);
    logic signed [63:0] z, dx, dy;
    z = 0;
    for (int i = 0; i < gcd_pkg::ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + arc_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - arc_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > quarter_turn) z = quarter_turn;
    return z;
  endfunction

  function automatic logic signed [63:0] clip_lat(input logic signed [63:0] v);
    if (v > gcd_pkg::LAT_POS) return gcd_pkg::LAT_POS;
    if (v < gcd_pkg::LAT_NEG) return gcd_pkg::LAT_NEG;
    return v;
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] haversine_cm(input probe_t pr);
    logic signed [63:0] la, oa, lb, ob, dlat, dlon, z;
    logic [63:0]  p, r, ca, cb, unused, m, t;
    logic [127:0] a, one120, d;
    la = pr.lat_a; oa = pr.lon_a; lb = pr.lat_b; ob = pr.lon_b;
    la = clip_lat(la);
    lb = clip_lat(lb);
    dlat = lb - la;
    if (dlat < 0) dlat = -dlat;
    dlon = ob - oa;
    while (dlon > gcd_pkg::HALF_TURN) dlon = dlon - gcd_pkg::FULL_TURN;
    while (dlon < -gcd_pkg::HALF_TURN) dlon = dlon + gcd_pkg::FULL_TURN;
    if (dlon < 0) dlon = -dlon;
    if (la < 0) la = -la;
    if (lb < 0) lb = -lb;
    sin_cos(half_rad(dlat), p, unused);
    sin_cos(half_rad(dlon), r, unused);
    sin_cos(half_rad(2 * la), unused, ca);
    sin_cos(half_rad(2 * lb), unused, cb);
    a = {64'b0, p} * {64'b0, p};
    d = ({64'b0, ca} * {64'b0, cb}) >> 60;
    m = d[63:0];
    d = ({64'b0, m} * {64'b0, r}) >> 60;
    t = d[63:0];
    a = a + {64'b0, t} * {64'b0, r};
    one120 = 128'd1 << 120;
    if (a > one120) a = one120;
    z = central_angle(root_floor(a), root_floor(one120 - a));
    d = (({64'b0, z} * {97'b0, gcd_pkg::RADIUS_CM2}) + (128'd1 << 59)) >> 60;
    if (d > gcd_pkg::DIST_MAX) return gcd_pkg::DIST_MAX;
    return d[gcd_pkg::DIST_W-1:0];
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // directed rows; distance typed only where the points coincide
  probe_t edge_rows [] = '{
    '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b1, 31'd0},
    '{31'sd900000000, 32'sd1800000000, 31'sd900000000, 32'sd1800000000, 1'b1, 31'd0},
    '{-31'sd900000000, -32'sd1800000000, -31'sd900000000, -32'sd1800000000, 1'b1, 31'd0},
    '{31'sh3fffffff, 32'sd5, 31'sd900000000, 32'sd5, 1'b1, 31'd0},
    '{31'sh40000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b1, 31'd0},
    '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, 1'b1, 31'd0},
    '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b0, 31'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 1'b0, 31'd0},
    '{31'sd0, 32'sh7fffffff, 31'sd0, 32'sh80000000, 1'b0, 31'd0},
    '{31'sh3fffffff, 32'sh80000000, 31'sh40000000, 32'sh7fffffff, 1'b0, 31'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1, 1'b0, 31'd0},
    '{31'sd0, 32'sd0, 31'sd1, 32'sd0, 1'b0, 31'd0},
    '{31'sd450000000, 32'sd100, -31'sd450000000, -32'sd1799999900, 1'b0, 31'd0},
    '{31'sd0, -32'sd900000001, 31'sd0, 32'sd900000000, 1'b0, 31'd0},
    '{31'sd0, 32'sd900000000, 31'sd0, -32'sd900000001, 1'b0, 31'd0},
    '{31'sd515000000, -32'sd1000000, 31'sd408000000, -32'sd739000000, 1'b0, 31'd0},
    '{-31'sd338000000, 32'sd1512000000, 31'sd515000000, -32'sd1000000, 1'b0, 31'd0},
    '{31'sd899999999, 32'sd0, 31'sd899999999, 32'sd1800000000, 1'b0, 31'd0}
  };

  function automatic probe_t random_probe();
    probe_t pr;
    int     kind;
    kind = $urandom_range(0, 99);
    pr.known    = 1'b0;
    pr.dist_val = '0;
    pr.lat_a = longint'($urandom_range(0, 1800000000)) - 900000000;
    pr.lon_a = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    if (kind < 55) begin
      pr.lat_b = longint'($urandom_range(0, 1800000000)) - 900000000;
      pr.lon_b = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    end else if (kind < 72) begin
      // short hops, up to 0.01 degree apart on each axis
      pr.lat_a = longint'($urandom_range(0, 1700000000)) - 850000000;
      pr.lon_a = longint'($urandom_range(0, 32'd3500000000)) - 1750000000;
      pr.lat_b = pr.lat_a + longint'($urandom_range(0, 200000)) - 100000;
      pr.lon_b = pr.lon_a + longint'($urandom_range(0, 200000)) - 100000;
    end else if (kind < 85) begin
      // close to the antipode
      pr.lon_a = $urandom_range(0, 1800000000);
      pr.lat_b = -pr.lat_a + longint'($urandom_range(0, 2000)) - 1000;
      pr.lon_b = pr.lon_a - 1800000000 + longint'($urandom_range(0, 2000));
    end else begin
      pr.lat_a = $urandom;
      pr.lon_a = $urandom;
      pr.lat_b = $urandom;
      pr.lon_b = $urandom;
    end
    return pr;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // sender
  initial begin
    probe_t pr;
    int     gap;
    int     total;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.lat_a = '0;
    in_ch.lon_a = '0;
    in_ch.lat_b = '0;
    in_ch.lon_b = '0;
    out_ch.ready = 1'b0;
    err_count = 0;
    sent_count = 0;
    stimulus_done = 1'b0;
    hold_off = 1'b0;
    calm = 1'b0;
    rx_wait = 0;
    build_trig_tables();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    total = edge_rows.size() + N_RANDOM;
    for (int n = 0; n < total; n++) begin
      @(negedge clk);
      pr = (n < edge_rows.size()) ? edge_rows[n] : random_probe();
      calm = (n >= 400 && n < 500);
      gap  = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.lat_a <= pr.lat_a;
      in_ch.lon_a <= pr.lon_a;
      in_ch.lat_b <= pr.lat_b;
      in_ch.lon_b <= pr.lon_b;
      do @(posedge clk); while (!in_ch.ready);
      dist_queue = {dist_queue, (pr.known ? pr.dist_val : haversine_cm(pr))};
      sent_count++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // long receiver hold-off so the pipeline fills and back-pressures
  initial begin
    wait (sent_count >= 120);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (700) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off || rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        if (rx_wait > 0) rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [gcd_pkg::DIST_W-1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (dist_queue.size() == 0) begin
        report($sformatf("unexpected distance %0d", out_ch.distance_cm));
      end else begin
        want = dist_queue.pop_front();
        if (out_ch.distance_cm !== want)
          report($sformatf("distance_cm %0d, expected %0d", out_ch.distance_cm, want));
      end
      rx_wait = calm ? 0 : $urandom_range(0, 10);
    end
  end

  initial begin
    wait (stimulus_done);
    while (dist_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (dist_queue.size() != 0) report("expected distances left over");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
